// File: src/mlqs_pkg.sv
// ----------------------------------------------------------------------------
// mlqs_pkg
// Shared types and constants of the multilevel queue scheduler: request and
// response payloads, per-task table access, level queue state and codes.
// ----------------------------------------------------------------------------
package mlqs_pkg;

  // Field widths
  localparam int OP_W        = 3;
  localparam int ID_W        = 6;
  localparam int LEVEL_W     = 2;
  localparam int SLICE_W     = 10;
  localparam int LEVEL_COUNT = 3;
  localparam int QIDX_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int TASK_SPAN   = 2 ** ID_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SET_LEVEL = 3'd0;
  localparam logic [OP_W-1:0] OP_ENQUEUE   = 3'd1;
  localparam logic [OP_W-1:0] OP_DEQUEUE   = 3'd2;
  localparam logic [OP_W-1:0] OP_YIELD     = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd4;
  localparam logic [OP_W-1:0] OP_PICK      = 3'd5;

  // Level codes
  localparam logic [LEVEL_W-1:0] LVL_NONE   = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_FIRST  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_SECOND = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_FCFS   = 2'd3;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLICE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SLICE = 1'b1;
  localparam logic [SLICE_W-1:0]   FIRST_SLICE_RST  = 10'd10;
  localparam logic [SLICE_W-1:0]   SECOND_SLICE_RST = 10'd20;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [ID_W-1:0]    task_id;
    logic [LEVEL_W-1:0] level;
  } req_t;

  typedef struct packed {
    logic            reschedule;
    logic            picked_valid;
    logic [ID_W-1:0] picked_task;
  } rsp_t;

  // One level FIFO: non-empty bit, head and tail task ids
  typedef struct packed {
    logic            ne;
    logic [ID_W-1:0] head;
    logic [ID_W-1:0] tail;
  } lvl_q_t;

  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] addr;
    logic [ID_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [SLICE_W-1:0] slice;
    logic               queued;
    logic [ID_W-1:0]    next;
    logic [ID_W-1:0]    prev;
  } tbl_rd_t;

  // Unlink writes go first, append writes override them
  typedef struct packed {
    logic [ID_W-1:0]    row_addr;
    logic               level_en;
    logic [LEVEL_W-1:0] level;
    logic               slice_en;
    logic [SLICE_W-1:0] slice;
    logic               queued_en;
    logic               queued;
    link_wr_t           next_ul;
    link_wr_t           next_ap;
    link_wr_t           prev_ul;
    link_wr_t           prev_ap;
  } tbl_wr_t;

  // Level code to queue index; an unused code falls on the last queue
  function automatic logic [QIDX_W-1:0] level_index(input logic [LEVEL_W-1:0] lvl);
    logic [QIDX_W-1:0] idx;
    idx = (lvl == LVL_NONE) ? QIDX_W'(LEVEL_COUNT - 1) : (lvl - LVL_FIRST);
    return idx;
  endfunction

endpackage

// File: src/mlqs_task_table.sv
// ----------------------------------------------------------------------------
// mlqs_task_table
// Per-task flop tables: level, slice left, queued flag and the next and
// previous links of the level FIFOs. One registered row read, row and link
// writes.
// ----------------------------------------------------------------------------
module mlqs_task_table
  import mlqs_pkg::*;
#(
  parameter int TASK_COUNT = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [ID_W-1:0] rd_addr,
  output tbl_rd_t         rd,
  input  tbl_wr_t         wr
);

  localparam int DEPTH = (TASK_COUNT < TASK_SPAN) ? TASK_COUNT : TASK_SPAN;
  localparam int IDX_W = $clog2(DEPTH);

  logic [LEVEL_W-1:0] level_tbl [DEPTH];
  logic [SLICE_W-1:0] slice_tbl [DEPTH];
  logic [DEPTH-1:0]   queued_tbl;
  logic [DEPTH-1:0]   written;
  logic [ID_W-1:0]    next_tbl  [DEPTH];
  logic [ID_W-1:0]    prev_tbl  [DEPTH];
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   row_idx;
  tbl_rd_t            rd_next;

  // Clamp the read index for ids past the table
  assign rd_idx  = (32'(rd_addr) < DEPTH) ? rd_addr[IDX_W-1:0] : '0;
  assign row_idx = wr.row_addr[IDX_W-1:0];

  // Look up the row, passing through writes that land on it at the same edge
  always_comb begin
    rd_next.level  = written[rd_idx] ? level_tbl[rd_idx] : LVL_FCFS;
    rd_next.slice  = written[rd_idx] ? slice_tbl[rd_idx] : '0;
    rd_next.queued = queued_tbl[rd_idx];
    rd_next.next   = next_tbl[rd_idx];
    rd_next.prev   = prev_tbl[rd_idx];
    if (wr.level_en && wr.row_addr == rd_addr) begin
      rd_next.level = wr.level;
    end
    if (wr.slice_en && wr.row_addr == rd_addr) begin
      rd_next.slice = wr.slice;
    end
    if (wr.queued_en && wr.row_addr == rd_addr) begin
      rd_next.queued = wr.queued;
    end
    if (wr.next_ul.en && wr.next_ul.addr == rd_addr) begin
      rd_next.next = wr.next_ul.data;
    end
    if (wr.next_ap.en && wr.next_ap.addr == rd_addr) begin
      rd_next.next = wr.next_ap.data;
    end
    if (wr.prev_ul.en && wr.prev_ul.addr == rd_addr) begin
      rd_next.prev = wr.prev_ul.data;
    end
    if (wr.prev_ap.en && wr.prev_ap.addr == rd_addr) begin
      rd_next.prev = wr.prev_ap.data;
    end
  end

  // Row read register
  always_ff @(posedge clk) begin
    rd <= rd_next;
  end

  // Flags: reset leaves every task unqueued and on level three with no slice
  always_ff @(posedge clk) begin
    if (rst) begin
      queued_tbl <= '0;
      written    <= '0;
    end else begin
      if (wr.level_en) begin
        written[row_idx] <= 1'b1;
      end
      if (wr.queued_en) begin
        queued_tbl[row_idx] <= wr.queued;
      end
    end
  end

  // Level and slice rows
  always_ff @(posedge clk) begin
    if (wr.level_en) begin
      level_tbl[row_idx] <= wr.level;
    end
    if (wr.slice_en) begin
      slice_tbl[row_idx] <= wr.slice;
    end
  end

  // Links: unlink first, then let the append write win
  always_ff @(posedge clk) begin
    if (wr.next_ul.en) begin
      next_tbl[wr.next_ul.addr[IDX_W-1:0]] <= wr.next_ul.data;
    end
    if (wr.next_ap.en) begin
      next_tbl[wr.next_ap.addr[IDX_W-1:0]] <= wr.next_ap.data;
    end
    if (wr.prev_ul.en) begin
      prev_tbl[wr.prev_ul.addr[IDX_W-1:0]] <= wr.prev_ul.data;
    end
    if (wr.prev_ap.en) begin
      prev_tbl[wr.prev_ap.addr[IDX_W-1:0]] <= wr.prev_ap.data;
    end
  end

endmodule

// File: src/mlqs_queue_update.sv
// ----------------------------------------------------------------------------
// mlqs_queue_update
// Single-pass operation logic: decodes a request, unlinks and appends the
// task on the level FIFOs, updates the slice and forms the response.
// ----------------------------------------------------------------------------
module mlqs_queue_update
  import mlqs_pkg::*;
#(
  parameter int TASK_COUNT = 64
) (
  input  logic                         commit,
  input  req_t                         req,
  input  tbl_rd_t                      row,
  input  lvl_q_t [LEVEL_COUNT-1:0]     queues,
  input  logic [SLICE_W-1:0]           first_slice,
  input  logic [SLICE_W-1:0]           second_slice,
  output tbl_wr_t                      wr,
  output lvl_q_t [LEVEL_COUNT-1:0]     queues_next,
  output rsp_t                         rsp
);

  logic                     id_ok;
  logic                     do_unlink;
  logic                     do_append;
  logic                     do_pick;
  logic                     resched;
  logic                     ul_act;
  logic                     is_head;
  logic                     is_tail;
  logic [QIDX_W-1:0]        cur_q;
  logic [QIDX_W-1:0]        app_q;
  lvl_q_t                   cur;
  lvl_q_t                   mid;
  lvl_q_t                   ap;
  lvl_q_t [LEVEL_COUNT-1:0] queues_ul;
  logic                     level_en;
  logic                     slice_en;
  logic [SLICE_W-1:0]       slice_val;

  function automatic logic [SLICE_W-1:0] slice_for(input logic [LEVEL_W-1:0] lvl,
                                                   input logic [SLICE_W-1:0] s1,
                                                   input logic [SLICE_W-1:0] s2);
    logic [SLICE_W-1:0] s;
    s = '0;
    if (lvl == LVL_FIRST) begin
      s = s1;
    end else if (lvl == LVL_SECOND) begin
      s = s2;
    end
    return s;
  endfunction

  assign id_ok = 32'(req.task_id) < TASK_COUNT;
  assign cur_q = level_index(row.level);

  // Select the queue of the task's present level
  always_comb begin
    cur = queues[0];
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (cur_q == QIDX_W'(i)) begin
        cur = queues[i];
      end
    end
  end

  // Decode the operation
  always_comb begin
    do_unlink = 1'b0;
    do_append = 1'b0;
    do_pick   = 1'b0;
    resched   = 1'b0;
    level_en  = 1'b0;
    slice_en  = 1'b0;
    slice_val = '0;
    app_q     = cur_q;
    if (req.opcode == OP_PICK) begin
      do_pick = 1'b1;
    end else if (id_ok) begin
      unique case (req.opcode)
        OP_SET_LEVEL: begin
          if (req.level != LVL_NONE) begin
            level_en  = 1'b1;
            slice_en  = 1'b1;
            slice_val = slice_for(req.level, first_slice, second_slice);
            if (row.queued) begin
              do_unlink = 1'b1;
              do_append = 1'b1;
              app_q     = level_index(req.level);
            end
          end
        end
        OP_ENQUEUE: begin
          do_unlink = 1'b1;
          do_append = 1'b1;
        end
        OP_DEQUEUE: begin
          do_unlink = 1'b1;
        end
        OP_YIELD: begin
          if (row.queued) begin
            do_unlink = 1'b1;
            do_append = 1'b1;
          end
        end
        OP_TICK: begin
          if (row.level == LVL_FIRST || row.level == LVL_SECOND) begin
            slice_en = 1'b1;
            if (row.slice > SLICE_W'(1)) begin
              slice_val = row.slice - SLICE_W'(1);
            end else begin
              slice_val = slice_for(row.level, first_slice, second_slice);
              if (row.queued && cur.tail != req.task_id) begin
                do_unlink = 1'b1;
                do_append = 1'b1;
                resched   = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Unlink the task from its present queue
  assign ul_act  = do_unlink && row.queued && cur.ne;
  assign is_head = cur.head == req.task_id;
  assign is_tail = cur.tail == req.task_id;

  always_comb begin
    mid = cur;
    if (ul_act) begin
      if (is_head) begin
        if (is_tail) begin
          mid.ne = 1'b0;
        end else begin
          mid.head = row.next;
        end
      end
      if (is_tail && !is_head) begin
        mid.tail = row.prev;
      end
    end
    queues_ul = queues;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (ul_act && cur_q == QIDX_W'(i)) begin
        queues_ul[i] = mid;
      end
    end
  end

  // Append the task at the tail of the target queue
  always_comb begin
    ap = queues_ul[0];
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (app_q == QIDX_W'(i)) begin
        ap = queues_ul[i];
      end
    end
    queues_next = queues_ul;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (do_append && app_q == QIDX_W'(i)) begin
        queues_next[i].ne   = 1'b1;
        queues_next[i].head = ap.ne ? ap.head : req.task_id;
        queues_next[i].tail = req.task_id;
      end
    end
  end

  // Table writes, held off unless the request commits
  always_comb begin
    wr.row_addr     = req.task_id;
    wr.level_en     = commit && level_en;
    wr.level        = req.level;
    wr.slice_en     = commit && slice_en;
    wr.slice        = slice_val;
    wr.queued_en    = commit && (ul_act || do_append);
    wr.queued       = do_append;
    wr.next_ul.en   = commit && ul_act && !is_head;
    wr.next_ul.addr = row.prev;
    wr.next_ul.data = row.next;
    wr.prev_ul.en   = commit && ul_act && !is_tail;
    wr.prev_ul.addr = row.next;
    wr.prev_ul.data = row.prev;
    wr.next_ap.en   = commit && do_append && ap.ne;
    wr.next_ap.addr = ap.tail;
    wr.next_ap.data = req.task_id;
    wr.prev_ap.en   = commit && do_append && ap.ne;
    wr.prev_ap.addr = req.task_id;
    wr.prev_ap.data = ap.tail;
  end

  // Response: pick reports the head of the first non-empty level
  always_comb begin
    rsp            = '0;
    rsp.reschedule = resched;
    if (do_pick) begin
      for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
        if (queues[i].ne) begin
          rsp.picked_valid = 1'b1;
          rsp.picked_task  = queues[i].head;
        end
      end
    end
  end

endmodule

// File: src/multilevel_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler_core
// Three-level task scheduler: two round robin levels with configured slices
// and one first come first served level, each a linked FIFO of task ids.
// ----------------------------------------------------------------------------
// Response: registered when the request held in the request register commits.
// Throughput: one request per cycle unless a response stalls on rsp_ready; each
//   request commits in the single pass from request to response register.
// Reset: all tasks on level three with no slice and unqueued, all queues
//   empty, slices 10 and 20; link tables are not cleared.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler_core
  import mlqs_pkg::*;
#(
  parameter int TASK_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLICE_W-1:0]   cfg_data,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp
);

  logic [SLICE_W-1:0]       first_level_slice;
  logic [SLICE_W-1:0]       second_level_slice;
  req_t                     req_reg;
  logic                     req_reg_valid;
  logic                     advance;
  logic [ID_W-1:0]          tbl_rd_addr;
  lvl_q_t [LEVEL_COUNT-1:0] queues;
  lvl_q_t [LEVEL_COUNT-1:0] queues_next;
  tbl_rd_t                  tbl_rd;
  tbl_wr_t                  tbl_wr;
  rsp_t                     upd_rsp;

  // Commit when a request is held and the response register is free
  assign advance   = req_reg_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_reg_valid || advance;

  // Read the row of the request about to be held
  assign tbl_rd_addr = (req_ready && req_valid) ? req.task_id : req_reg.task_id;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_level_slice  <= FIRST_SLICE_RST;
      second_level_slice <= SECOND_SLICE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FIRST_SLICE:  first_level_slice  <= cfg_data;
        CFG_SECOND_SLICE: second_level_slice <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_reg_valid <= 1'b0;
    end else if (req_ready) begin
      req_reg_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      req_reg <= req;
    end
  end

  // Level queues
  always_ff @(posedge clk) begin
    if (rst) begin
      queues <= '0;
    end else if (advance) begin
      queues <= queues_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= upd_rsp;
    end
  end

  mlqs_task_table #(
    .TASK_COUNT (TASK_COUNT)
  ) u_task_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (tbl_rd_addr),
    .rd      (tbl_rd),
    .wr      (tbl_wr)
  );

  mlqs_queue_update #(
    .TASK_COUNT (TASK_COUNT)
  ) u_queue_update (
    .commit       (advance),
    .req          (req_reg),
    .row          (tbl_rd),
    .queues       (queues),
    .first_slice  (first_level_slice),
    .second_slice (second_level_slice),
    .wr           (tbl_wr),
    .queues_next  (queues_next),
    .rsp          (upd_rsp)
  );

  // A queued task sits on a non-empty queue of its own level
  a_queued_on_nonempty: assert property (@(posedge clk) disable iff (rst)
    req_reg_valid && tbl_rd.queued |->
      (tbl_rd.level == LVL_FIRST && queues[0].ne) ||
      (tbl_rd.level == LVL_SECOND && queues[1].ne) ||
      (tbl_rd.level == LVL_FCFS && queues[2].ne))
    else $error("queued task on an empty level queue");

  // Stored levels never take the unused code
  a_level_code: assert property (@(posedge clk) disable iff (rst)
    req_reg_valid |-> tbl_rd.level != LVL_NONE)
    else $error("task level table holds level zero");

  // A held request stays put until it commits
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_reg_valid && !advance |=> req_reg_valid && $stable(req_reg))
    else $error("held request lost or changed");

  // Reschedule comes only from a tick
  a_resched_tick: assert property (@(posedge clk) disable iff (rst)
    advance && upd_rsp.reschedule |-> req_reg.opcode == OP_TICK)
    else $error("reschedule raised by an operation other than tick");

  // A committed response is what the register shows next
  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid && rsp == $past(upd_rsp))
    else $error("response register not loaded on commit");

endmodule

// File: dv/multilevel_queue_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler_core_tb
// Self-checking bench for the three-level scheduler. Scheduler requests
// (directed corner cases, then random traffic over a small task pool) are
// driven on a valid/ready channel under several slice settings. A shadow copy
// of the task tables and level FIFOs predicts every response, and each
// response is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler_core_tb;
  import mlqs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes the block treats as no-operations
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 170;

  localparam logic [ID_W-1:0] LAST_TASK = ID_W'(TASK_SPAN - 1);

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FIRST_SLICE;
  logic [SLICE_W-1:0]   cfg_data  = '0;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_t                 req       = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_t                 rsp;

  multilevel_queue_scheduler_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5ns clk = ~clk;

  // Shadow scheduler state
  logic [LEVEL_W-1:0] task_level [TASK_SPAN];
  logic [SLICE_W-1:0] slice_left [TASK_SPAN];
  logic               on_queue   [TASK_SPAN];
  logic [ID_W-1:0]    link_next  [TASK_SPAN];
  logic [ID_W-1:0]    link_prev  [TASK_SPAN];
  lvl_q_t             level_fifo [LEVEL_COUNT];
  logic [SLICE_W-1:0] first_slice;
  logic [SLICE_W-1:0] second_slice;

  req_t op_backlog[$];
  rsp_t outcome_fifo[$];
  int   errors      = 0;
  int   quiet_count = 0;
  int   hold_left   = 0;
  logic hold_ask    = 1'b0;
  logic gaps_on     = 1'b1;
  logic req_taken   = 1'b0;

  function automatic int fifo_of(logic [ID_W-1:0] t);
    if (task_level[t] == LVL_FIRST) return 0;
    if (task_level[t] == LVL_SECOND) return 1;
    return LEVEL_COUNT - 1;
  endfunction

  function automatic logic [SLICE_W-1:0] reload_of(logic [LEVEL_W-1:0] lvl);
    if (lvl == LVL_FIRST) return first_slice;
    if (lvl == LVL_SECOND) return second_slice;
    return '0;
  endfunction

  function automatic void reset_shadow();
    first_slice  = FIRST_SLICE_RST;
    second_slice = SECOND_SLICE_RST;
    for (int i = 0; i < TASK_SPAN; i++) begin
      task_level[i] = LVL_FCFS;
      slice_left[i] = '0;
      on_queue[i]   = 1'b0;
      link_next[i]  = '0;
      link_prev[i]  = '0;
    end
    for (int i = 0; i < LEVEL_COUNT; i++) level_fifo[i] = '0;
  endfunction

  // Take a task out of its level FIFO, patching its neighbours
  function automatic void detach_task(logic [ID_W-1:0] t);
    int              qi;
    logic [ID_W-1:0] p;
    logic [ID_W-1:0] n;
    qi = fifo_of(t);
    p  = link_prev[t];
    n  = link_next[t];
    if (!on_queue[t] || !level_fifo[qi].ne) return;
    if (level_fifo[qi].head == t) begin
      if (level_fifo[qi].tail == t) level_fifo[qi].ne = 1'b0;
      else level_fifo[qi].head = n;
    end else begin
      link_next[p] = n;
    end
    if (level_fifo[qi].tail == t) begin
      if (level_fifo[qi].head != t) level_fifo[qi].tail = p;
    end else begin
      link_prev[n] = p;
    end
    on_queue[t] = 1'b0;
  endfunction

  // Add a task at the tail of its level FIFO
  function automatic void attach_task(logic [ID_W-1:0] t);
    int qi;
    qi = fifo_of(t);
    if (!level_fifo[qi].ne) begin
      level_fifo[qi].head = t;
      level_fifo[qi].ne   = 1'b1;
    end else begin
      link_next[level_fifo[qi].tail] = t;
      link_prev[t] = level_fifo[qi].tail;
    end
    level_fifo[qi].tail = t;
    on_queue[t] = 1'b1;
  endfunction

  // Apply one request to the shadow state and return the response it gives
  function automatic rsp_t schedule_outcome(req_t r);
    rsp_t            res;
    logic [ID_W-1:0] t;
    logic            found;
    res   = '0;
    t     = r.task_id;
    found = 1'b0;
    case (r.opcode)
      OP_PICK: begin
        for (int i = 0; i < LEVEL_COUNT; i++) begin
          if (!found && level_fifo[i].ne) begin
            found            = 1'b1;
            res.picked_valid = 1'b1;
            res.picked_task  = level_fifo[i].head;
          end
        end
      end
      OP_SET_LEVEL: begin
        if (r.level != LVL_NONE) begin
          if (on_queue[t]) begin
            detach_task(t);
            task_level[t] = r.level;
            attach_task(t);
          end else begin
            task_level[t] = r.level;
          end
          slice_left[t] = reload_of(r.level);
        end
      end
      OP_ENQUEUE: begin
        detach_task(t);
        attach_task(t);
      end
      OP_DEQUEUE: detach_task(t);
      OP_YIELD: begin
        if (on_queue[t]) begin
          detach_task(t);
          attach_task(t);
        end
      end
      OP_TICK: begin
        if (task_level[t] == LVL_FIRST || task_level[t] == LVL_SECOND) begin
          if (slice_left[t] > 1) begin
            slice_left[t] = slice_left[t] - 1'b1;
          end else begin
            slice_left[t] = reload_of(task_level[t]);
            if (on_queue[t] && level_fifo[fifo_of(t)].tail != t) begin
              detach_task(t);
              attach_task(t);
              res.reschedule = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Request driver: hold the request until taken, then offer the next one
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_taken)) begin
      if (op_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < 26)) begin
        req       <= op_backlog.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response sink: random back-pressure plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !(gaps_on && $urandom_range(99) < 26);
    end
  end

  task automatic report(string field, int want, int got);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endtask

  // Monitor: predict on each accepted request, check each accepted response
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      req_taken <= req_valid && req_ready;
      if (rsp_valid && rsp_ready) begin
        if (outcome_fifo.size() == 0) begin
          $display("%0t ns: response with none expected, actual %h", $time, rsp);
          errors++;
        end else begin
          want = outcome_fifo.pop_front();
          if (rsp.reschedule !== want.reschedule)
            report("reschedule", want.reschedule, rsp.reschedule);
          if (rsp.picked_valid !== want.picked_valid)
            report("picked_valid", want.picked_valid, rsp.picked_valid);
          if (rsp.picked_task !== want.picked_task)
            report("picked_task", want.picked_task, rsp.picked_task);
        end
      end
      if (req_valid && req_ready) outcome_fifo.push_back(schedule_outcome(req));
      // Watchdog on handshake activity
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
        if (quiet_count >= QUIET_LIMIT) begin
          $display("%0t ns: no handshake for %0d cycles", $time, quiet_count);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  task automatic post(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [LEVEL_W-1:0] lvl);
    req_t r;
    r.opcode  = op;
    r.task_id = id;
    r.level   = lvl;
    op_backlog.push_back(r);
  endtask

  // Wait until every request is sent and answered, then let the block settle
  task automatic drain();
    while (op_backlog.size() != 0 || req_valid || outcome_fifo.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_slices(logic [SLICE_W-1:0] s1, logic [SLICE_W-1:0] s2);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FIRST_SLICE;
    cfg_data  <= s1;
    @(negedge clk);
    first_slice = s1;
    cfg_index <= CFG_SECOND_SLICE;
    cfg_data  <= s2;
    @(negedge clk);
    second_slice = s2;
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Random request, mostly on a small pool of tasks so that FIFOs get deep
  function automatic req_t random_request();
    req_t r;
    int   roll;
    roll      = $urandom_range(99);
    r.level   = LEVEL_W'($urandom_range(3));
    r.task_id = ($urandom_range(99) < 70) ? ID_W'($urandom_range(7))
                                          : ID_W'($urandom_range(TASK_SPAN - 1));
    if (roll < 10) begin
      r.opcode = OP_SET_LEVEL;
      r.level  = ($urandom_range(19) == 0) ? LVL_NONE : LEVEL_W'($urandom_range(3, 1));
    end else if (roll < 35) r.opcode = OP_ENQUEUE;
    else if (roll < 45) r.opcode = OP_DEQUEUE;
    else if (roll < 55) r.opcode = OP_YIELD;
    else if (roll < 80) r.opcode = OP_TICK;
    else if (roll < 95) r.opcode = OP_PICK;
    else if (roll < 98) r.opcode = OP_SPARE_LO;
    else r.opcode = OP_SPARE_HI;
    return r;
  endfunction

  task automatic random_phase(logic [SLICE_W-1:0] s1, logic [SLICE_W-1:0] s2,
                              logic gaps, logic with_hold);
    write_slices(s1, s2);
    gaps_on = gaps;
    for (int i = 0; i < PHASE_ITEMS; i++) op_backlog.push_back(random_request());
    if (with_hold) begin
      @(posedge clk);
      hold_ask = 1'b1;
    end
    drain();
  endtask

  initial begin
    reset_shadow();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corner cases under short slices
    write_slices(10'd2, 10'd3);
    post(OP_SET_LEVEL, 6'd0, LVL_FIRST);
    post(OP_SET_LEVEL, LAST_TASK, LVL_SECOND);
    post(OP_SET_LEVEL, 6'd7, LVL_NONE);        // level none: ignored
    post(OP_PICK, LAST_TASK, LVL_FCFS);        // nothing queued yet
    post(OP_ENQUEUE, 6'd7, LVL_NONE);
    post(OP_ENQUEUE, LAST_TASK, LVL_FIRST);
    post(OP_PICK, 6'd0, LVL_NONE);
    post(OP_ENQUEUE, 6'd0, LVL_SECOND);
    post(OP_SET_LEVEL, 6'd1, LVL_FIRST);
    post(OP_ENQUEUE, 6'd1, LVL_NONE);
    post(OP_PICK, 6'd5, LVL_SECOND);
    post(OP_TICK, 6'd0, LVL_NONE);
    post(OP_TICK, 6'd0, LVL_NONE);              // expiry, not last: reschedule
    post(OP_TICK, 6'd7, LVL_FCFS);              // level three: no slice
    post(OP_YIELD, 6'd1, LVL_NONE);
    post(OP_DEQUEUE, 6'd40, LVL_NONE);          // task not queued
    post(OP_YIELD, 6'd40, LVL_FCFS);            // task not queued
    post(OP_ENQUEUE, 6'd0, LVL_NONE);           // already queued: move to tail
    post(OP_SET_LEVEL, 6'd1, LVL_SECOND);       // queued task changes level
    post(OP_TICK, 6'd0, LVL_NONE);
    post(OP_TICK, 6'd0, LVL_NONE);              // expiry as last: reload only
    post(OP_DEQUEUE, LAST_TASK, LVL_NONE);      // head of its FIFO
    post(OP_SPARE_LO, 6'd0, LVL_FIRST);
    post(OP_SPARE_HI, LAST_TASK, LVL_FCFS);
    post(OP_PICK, 6'd0, LVL_NONE);
    drain();

    // Random traffic across slice settings, extremes among them
    random_phase(10'd1, 10'd1, 1'b1, 1'b1);
    random_phase(10'd1023, 10'd1023, 1'b0, 1'b0);
    random_phase(10'd3, 10'd7, 1'b1, 1'b0);
    random_phase(10'd1, 10'd1023, 1'b1, 1'b1);
    random_phase(SLICE_W'($urandom_range(9, 2)), SLICE_W'($urandom_range(9, 2)), 1'b1, 1'b0);

    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
